FILE: design/rfc_pkg.sv
`default_nettype none
package rfc_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int IO_BITS = 32;
	localparam int TOL_BITS = 31;
	localparam int LIM_BITS = 8;
	localparam logic [TOL_BITS-1:0] TOL_RESET = 31'd66;
	localparam logic [LIM_BITS-1:0] LIM_RESET = 8'd64;
	localparam logic CFG_TOLERANCE = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		OUT_CONVERGED = 2'd0,
		OUT_NO_SIGN   = 2'd1,
		OUT_ZERO_DIV  = 2'd2,
		OUT_LIMIT     = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1
	} op_t;
endpackage
`default_nettype wire

FILE: design/regula_falsi_cubic_root.sv
`default_nettype none
// channel | signals                                   | handshake
// request | start, bound_first, bound_second          | start && !busy
// result  | done, root_estimate, residual,            | one-cycle strobe
//         | iterations_used, outcome                  |
// config  | cfg_valid, cfg_index, cfg_data, cfg_ready | cfg_valid && cfg_ready
// Each f(x) runs three steps: square, cube, combine; first at both ends.
// Each iteration then runs a restoring muldiv on the shared unit plus its
// issue and handoff, the new point, f at it and the decision.
// arst_n clears the sequencer, done and the tolerance and limit registers to their reset values.
// The receiver cannot stall; a result shows on done for one cycle.
module regula_falsi_cubic_root import rfc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire signed [IO_BITS-1:0]  bound_first,
	input  wire signed [IO_BITS-1:0]  bound_second,
	output logic                      busy,
	output logic                      done,
	output logic signed [IO_BITS-1:0] root_estimate,
	output logic signed [IO_BITS-1:0] residual,
	output logic [LIM_BITS-1:0]       iterations_used,
	output logic [1:0]                outcome,
	input  wire                       cfg_valid,
	input  wire                       cfg_index,
	input  wire [IO_BITS-1:0]         cfg_data,
	output logic                      cfg_ready
);
	localparam int W = WORD_BITS;
	localparam int IW = (W > IO_BITS) ? W : IO_BITS;
	localparam int TW = (W > TOL_BITS) ? W : TOL_BITS;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_SQ   = 8'b00000010,
		S_CU   = 8'b00000100,
		S_F    = 8'b00001000,
		S_CHK  = 8'b00010000,
		S_DIV  = 8'b00100000,
		S_NEWC = 8'b01000000,
		S_DEC  = 8'b10000000
	} state_t;

	state_t state_q;
	logic [TOL_BITS-1:0] tol_q;
	logic [LIM_BITS-1:0] lim_q, iter_q;
	logic signed [W-1:0] a_q, b_q, c_q, fa_q, fb_q, fc_q, x_q;
	logic [1:0] which_q;

	logic go;
	op_t op;
	logic signed [W:0] ux, uy;
	logic signed [W+1:0] uz;
	logic udone;
	logic signed [W-1:0] ures;

	rfc_unit #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(W)) u_unit (
		.clk(clk), .arst_n(arst_n), .go(go), .op(op), .x(ux), .y(uy), .z(uz),
		.done(udone), .res(ures)
	);

	function automatic logic signed [W-1:0] sat_in(input logic signed [IO_BITS-1:0] v);
		logic signed [IW:0] e, mx, mn;
		e = (IW+1)'(v);
		mx = (IW+1)'({1'b0, {(W-1){1'b1}}});
		mn = -mx - 1'b1;
		sat_in = (e > mx) ? W'(mx) : (e < mn) ? W'(mn) : W'(e);
	endfunction

	function automatic logic signed [IO_BITS-1:0] sat_out(input logic signed [W-1:0] v);
		logic signed [IW:0] e, mx, mn;
		e = (IW+1)'(v);
		mx = (IW+1)'({1'b0, {(IO_BITS-1){1'b1}}});
		mn = -mx - 1'b1;
		sat_out = (e > mx) ? IO_BITS'(mx) : (e < mn) ? IO_BITS'(mn) : IO_BITS'(e);
	endfunction

	localparam int FW = W + 5;
	logic signed [FW-1:0] fsum, wmax_f, wmin_f, csum, wmax_c, wmin_c;
	logic signed [W-1:0] fval, cval;
	logic [W-1:0] fmag;
	logic tol_hit;
	logic [LIM_BITS-1:0] lim_eff;
	assign wmax_f = FW'({1'b0, {(W-1){1'b1}}});
	assign wmin_f = -wmax_f - 1'b1;
	assign fsum = FW'(ures) - FW'(x_q) * FW'(7) + (FW'(1) <<< FRAC_BITS);
	assign fval = (fsum > wmax_f) ? W'(wmax_f) : (fsum < wmin_f) ? W'(wmin_f) : W'(fsum);
	assign csum = FW'(a_q) - FW'(ures);
	assign wmax_c = wmax_f;
	assign wmin_c = wmin_f;
	assign cval = (csum > wmax_c) ? W'(wmax_c) : (csum < wmin_c) ? W'(wmin_c) : W'(csum);
	assign fmag = fc_q[W-1] ? W'(-fc_q) : W'(fc_q);
	assign tol_hit = TW'(fmag) < TW'(tol_q);
	assign lim_eff = (lim_q == '0) ? LIM_BITS'(1) : lim_q;

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		go = 1'b0;
		op = OP_MUL;
		ux = (W+1)'(x_q);
		uy = (W+1)'(x_q);
		uz = (W+2)'(fb_q) - (W+2)'(fa_q);
		case (state_q)
			S_SQ: go = 1'b1;
			S_CU: begin
				go = udone;
				uy = (W+1)'(ures);
			end
			S_CHK: begin
				go = (fb_q != fa_q);
				op = OP_DIV;
				ux = (W+1)'(fa_q);
				uy = (W+1)'(b_q) - (W+1)'(a_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tol_q <= TOL_RESET;
			lim_q <= LIM_RESET;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == CFG_TOLERANCE) tol_q <= cfg_data[TOL_BITS-1:0];
				else lim_q <= cfg_data[LIM_BITS-1:0];
			end
			case (state_q)
				S_IDLE: if (start) state_q <= S_SQ;
				S_SQ: state_q <= S_CU;
				S_CU: if (udone) state_q <= S_F;
				S_F: if (udone) state_q <= (which_q == 2'd0) ? S_SQ :
						(which_q == 2'd1) ? S_CHK : S_DEC;
				S_CHK: begin
					if (fb_q == fa_q) begin
						done <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: if (udone) state_q <= S_NEWC;
				S_NEWC: state_q <= S_SQ;
				S_DEC: begin
					if (!tol_hit && iter_q < lim_eff
							&& ((fa_q > 0 && fc_q > 0) || (fa_q < 0 && fc_q < 0)
							|| (fb_q > 0 && fc_q > 0) || (fb_q < 0 && fc_q < 0))) begin
						state_q <= S_CHK;
					end else begin
						done <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) begin
				a_q <= sat_in(bound_first);
				b_q <= sat_in(bound_second);
				x_q <= sat_in(bound_first);
				which_q <= 2'd0;
				iter_q <= LIM_BITS'(1);
			end
			S_F: if (udone) begin
				case (which_q)
					2'd0: begin
						fa_q <= fval;
						x_q <= b_q;
						which_q <= 2'd1;
					end
					2'd1: fb_q <= fval;
					default: fc_q <= fval;
				endcase
			end
			S_CHK: if (fb_q == fa_q) begin
				root_estimate <= sat_out(a_q);
				residual <= sat_out(fa_q);
				iterations_used <= iter_q;
				outcome <= OUT_ZERO_DIV;
			end
			S_NEWC: begin
				c_q <= cval;
				x_q <= cval;
				which_q <= 2'd2;
			end
			S_DEC: begin
				root_estimate <= sat_out(c_q);
				residual <= sat_out(fc_q);
				iterations_used <= iter_q;
				if (tol_hit) outcome <= OUT_CONVERGED;
				else if (iter_q >= lim_eff) outcome <= OUT_LIMIT;
				else if ((fa_q > 0 && fc_q > 0) || (fa_q < 0 && fc_q < 0)) begin
					a_q <= c_q;
					fa_q <= fc_q;
					iter_q <= iter_q + 1'b1;
				end else if ((fb_q > 0 && fc_q > 0) || (fb_q < 0 && fc_q < 0)) begin
					b_q <= c_q;
					fb_q <= fc_q;
					iter_q <= iter_q + 1'b1;
				end else outcome <= OUT_NO_SIGN;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: design/rfc_unit.sv
`default_nettype none
// Shared multiply / muldiv unit on magnitudes.
// OP_MUL: registered, q = (|x|*|y|) >> FRAC, saturated to the word range.
// OP_DIV: |x|*|y| / |z| by restoring division, one quotient bit per cycle.
// Results are signed, saturated to the WORD_BITS range.
module rfc_unit import rfc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        go,
	input  op_t                        op,
	input  wire signed [WORD_BITS:0]   x,
	input  wire signed [WORD_BITS:0]   y,
	input  wire signed [WORD_BITS+1:0] z,
	output logic                       done,
	output logic signed [WORD_BITS-1:0] res
);
	localparam int PW = 2 * WORD_BITS + 2;
	localparam int CW = $clog2(PW + 1);
	localparam logic [PW-1:0] WMAX = {{(PW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};

	logic [PW-1:0] prod_q, quo_q;
	logic [WORD_BITS+2:0] rem_q;
	logic [WORD_BITS+1:0] dv_q;
	logic [CW-1:0] cnt_q;
	logic neg_q, busy_q;

	logic [WORD_BITS:0] mx, my;
	logic [WORD_BITS+1:0] mz;
	logic [PW-1:0] prod, mshift;
	logic [WORD_BITS+2:0] rem_sh;
	logic ge;

	assign mx = x[WORD_BITS] ? -x : x;
	assign my = y[WORD_BITS] ? -y : y;
	assign mz = z[WORD_BITS+1] ? -z : z;
	assign prod = PW'(mx) * PW'(my);
	assign mshift = prod >> FRAC_BITS;
	assign rem_sh = {rem_q[WORD_BITS+1:0], prod_q[PW-1]};
	assign ge = rem_sh >= {1'b0, dv_q};

	function automatic logic signed [WORD_BITS-1:0] sat(input logic [PW-1:0] m,
			input logic n);
		logic [PW-1:0] v;
		v = (m > WMAX) ? (n ? WMAX + 1'b1 : WMAX) : m;
		sat = n ? WORD_BITS'(-v) : WORD_BITS'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go && op == OP_MUL) begin
				done <= 1'b1;
			end else if (go) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(PW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= x[WORD_BITS] ^ y[WORD_BITS] ^ (op == OP_DIV && z[WORD_BITS+1]);
			prod_q <= prod;
			dv_q <= mz;
			rem_q <= '0;
			quo_q <= '0;
			if (op == OP_MUL) begin
				res <= sat(mshift, x[WORD_BITS] ^ y[WORD_BITS]);
			end
		end else if (busy_q) begin
			prod_q <= prod_q << 1;
			rem_q <= ge ? rem_sh - {1'b0, dv_q} : rem_sh;
			quo_q <= {quo_q[PW-2:0], ge};
			if (cnt_q == CW'(1)) begin
				res <= sat({quo_q[PW-2:0], ge}, neg_q);
			end
		end
	end
endmodule
`default_nettype wire
